>>> rtl/clms_pkg.sv
package clms_pkg;

  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned WeightBitsDef = 24;
  localparam int unsigned PhaseItersDef = 16;
  localparam int unsigned MuBits        = 16;
  localparam int unsigned PhaseBits     = 16;
  localparam int unsigned AngBits       = 32;
  localparam int unsigned AtanDepth     = 24;
  localparam int unsigned CfgIdxBits    = 2;

  localparam logic [CfgIdxBits-1:0] CfgStepSize = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgRefReal  = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgRefImag  = 2'd2;

  localparam logic [MuBits-1:0] StepSizeRst = 16'd256;

  function automatic logic [AngBits-1:0] atan_turn(input logic [4:0] idx);
    logic [AngBits-1:0] r;
    r = '0;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/clms_lms.sv
module clms_lms import clms_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned WeightBits = WeightBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic [MuBits-1:0]            mu_i,
  input  logic signed [SampleBits-1:0] ref_re_i,
  input  logic signed [SampleBits-1:0] ref_im_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [4*SampleBits-1:0]      in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2*SampleBits+3:0]      out_data_o
);

  localparam int unsigned EB = SampleBits + 2;
  localparam int unsigned PB = SampleBits + WeightBits;
  localparam int unsigned AB = PB + 3;
  localparam int unsigned WF = WeightBits - 4;
  localparam int unsigned SF = SampleBits - 1;
  localparam int unsigned GB = EB + SampleBits + 1;
  localparam int unsigned GRB = GB - SF + 1;
  localparam int unsigned MB = GRB + MuBits + 1;
  localparam int Us = int'(SampleBits) - int'(WeightBits) + 19;
  localparam int unsigned SB = MB + ((Us < 0) ? -Us : 0);
  localparam int unsigned ZB = ((SB > WeightBits) ? SB : WeightBits) + 2;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StErr  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;
  localparam logic [1:0] StOut  = 2'd3;

  logic [1:0] state_q, state_d;
  logic signed [SampleBits-1:0] s_q [4];
  logic signed [WeightBits-1:0] w_q [4];
  logic signed [PB-1:0] p_q [8];
  logic signed [EB-1:0] er_q, ei_q;
  logic signed [GB-1:0] g_q [4];
  logic out_valid_q;
  logic [2*EB-1:0] out_q;

  function automatic logic signed [EB-1:0] err_of(input logic signed [AB-1:0] yv,
                                                  input logic signed [SampleBits-1:0] dv);
    logic signed [AB-1:0] t;
    logic signed [AB-WF-1:0] r;
    t = ({{(AB-SampleBits){dv[SampleBits-1]}}, dv} <<< WF) - yv
        + (AB'(1) <<< (WF - 1));
    r = t[AB-1:WF];
    if (r > $signed((AB-WF)'((1 << (EB-1)) - 1))) return {1'b0, {(EB-1){1'b1}}};
    if (r < -$signed((AB-WF)'(1 << (EB-1)))) return {1'b1, {(EB-1){1'b0}}};
    return r[EB-1:0];
  endfunction

  function automatic logic signed [WeightBits-1:0] upd(input logic signed [WeightBits-1:0] w,
                                                       input logic signed [GB-1:0] g,
                                                       input logic [MuBits-1:0] mu);
    logic signed [GB-1:0] gt;
    logic signed [GRB-1:0] gr;
    logic signed [MB-1:0] m;
    logic signed [SB-1:0] sc;
    logic signed [ZB-1:0] z;
    gt = g + GB'(1 <<< (SF - 1));
    gr = GRB'(gt >>> SF);
    m = MB'(gr) * $signed({1'b0, mu});
    if (Us > 0) sc = SB'((m + MB'(1 <<< ((Us > 0 ? Us : 1) - 1))) >>> (Us > 0 ? Us : 0));
    else sc = SB'(m) <<< (Us < 0 ? -Us : 0);
    z = ZB'(w) + ZB'(sc);
    if (z > $signed(ZB'((1 << (WeightBits-1)) - 1))) return {1'b0, {(WeightBits-1){1'b1}}};
    if (z < -$signed(ZB'(1 << (WeightBits-1)))) return {1'b1, {(WeightBits-1){1'b0}}};
    return z[WeightBits-1:0];
  endfunction

  assign in_ready_o = (state_q == StIdle) && !clear_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_valid_i && in_ready_o) state_d = StErr;
      StErr:  state_d = StUpd;
      StUpd:  state_d = StOut;
      StOut:  if (!out_valid_q || out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) w_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (clear_i) begin
        for (int i = 0; i < 4; i++) w_q[i] <= '0;
      end else if (state_q == StOut && state_d == StIdle) begin
        w_q[0] <= upd(w_q[0], g_q[0], mu_i);
        w_q[1] <= upd(w_q[1], g_q[1], mu_i);
        w_q[2] <= upd(w_q[2], g_q[2], mu_i);
        w_q[3] <= upd(w_q[3], g_q[3], mu_i);
      end
      if (state_q == StOut && state_d == StIdle) out_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i && in_ready_o) begin
      for (int i = 0; i < 4; i++) s_q[i] <= in_data_i[i*SampleBits +: SampleBits];
      p_q[0] <= w_q[0] * $signed(in_data_i[0 +: SampleBits]);
      p_q[1] <= w_q[1] * $signed(in_data_i[SampleBits +: SampleBits]);
      p_q[2] <= w_q[2] * $signed(in_data_i[2*SampleBits +: SampleBits]);
      p_q[3] <= w_q[3] * $signed(in_data_i[3*SampleBits +: SampleBits]);
      p_q[4] <= w_q[0] * $signed(in_data_i[SampleBits +: SampleBits]);
      p_q[5] <= w_q[1] * $signed(in_data_i[0 +: SampleBits]);
      p_q[6] <= w_q[2] * $signed(in_data_i[3*SampleBits +: SampleBits]);
      p_q[7] <= w_q[3] * $signed(in_data_i[2*SampleBits +: SampleBits]);
    end
    if (state_q == StErr) begin
      er_q <= err_of(AB'(p_q[0]) - AB'(p_q[1]) + AB'(p_q[2]) - AB'(p_q[3]), ref_re_i);
      ei_q <= err_of(AB'(p_q[4]) + AB'(p_q[5]) + AB'(p_q[6]) + AB'(p_q[7]), ref_im_i);
    end
    if (state_q == StUpd) begin
      g_q[0] <= GB'(er_q) * GB'(s_q[0]) + GB'(ei_q) * GB'(s_q[1]);
      g_q[1] <= GB'(ei_q) * GB'(s_q[0]) - GB'(er_q) * GB'(s_q[1]);
      g_q[2] <= GB'(er_q) * GB'(s_q[2]) + GB'(ei_q) * GB'(s_q[3]);
      g_q[3] <= GB'(ei_q) * GB'(s_q[2]) - GB'(er_q) * GB'(s_q[3]);
    end
    if (state_q == StOut && state_d == StIdle) out_q <= {ei_q, er_q};
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/clms_fifo.sv
module clms_fifo import clms_pkg::*; #(
  parameter int unsigned Width = 36
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [Width-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [Width-1:0] out_data_o
);

  logic [Width-1:0] mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic wr, rd;

  assign in_ready_o  = cnt_q != 2'd2;
  assign out_valid_o = cnt_q != 2'd0;
  assign wr = in_valid_i && in_ready_o;
  assign rd = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= ~wp_q;
      if (rd) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_data_i;
  end

endmodule

>>> rtl/clms_phase.sv
module clms_phase import clms_pkg::*; #(
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned PhaseIters = PhaseItersDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [2*SampleBits+3:0] in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2*SampleBits+PhaseBits+3:0] out_data_o
);

  localparam int unsigned EB = SampleBits + 2;
  localparam int unsigned XB = EB + 18;
  localparam int unsigned NIt = (PhaseIters < AtanDepth) ? PhaseIters : AtanDepth;
  localparam int unsigned IB = $clog2(NIt + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun  = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;

  logic [1:0] state_q;
  logic [IB-1:0] it_q;
  logic signed [XB-1:0] x_q, y_q;
  logic [AngBits-1:0] z_q;
  logic zero_q;
  logic [2*EB-1:0] e_q;
  logic signed [EB-1:0] er, ei;

  assign er = in_data_i[EB-1:0];
  assign ei = in_data_i[2*EB-1:EB];
  assign in_ready_o = state_q == StIdle;
  assign out_valid_o = state_q == StOut;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      it_q <= '0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          state_q <= (NIt == 0) ? StOut : StRun;
          it_q <= '0;
        end
        StRun: begin
          it_q <= it_q + 1'b1;
          if (32'(it_q) == NIt - 1) state_q <= StOut;
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_valid_i) begin
      e_q <= in_data_i[2*EB-1:0];
      zero_q <= (er == '0) && (ei == '0);
      if (er < 0) begin
        x_q <= -(XB'(er) <<< 16);
        y_q <= -(XB'(ei) <<< 16);
        z_q <= 32'h80000000;
      end else begin
        x_q <= XB'(er) <<< 16;
        y_q <= XB'(ei) <<< 16;
        z_q <= '0;
      end
    end else if (state_q == StRun) begin
      if (y_q > 0) begin
        x_q <= x_q + (y_q >>> it_q);
        y_q <= y_q - (x_q >>> it_q);
        z_q <= z_q + atan_turn(5'(it_q));
      end else begin
        x_q <= x_q - (y_q >>> it_q);
        y_q <= y_q + (x_q >>> it_q);
        z_q <= z_q - atan_turn(5'(it_q));
      end
    end
  end

  logic [AngBits-1:0] zr;
  assign zr = z_q + 32'h8000;
  assign out_data_o = {e_q, zero_q ? {PhaseBits{1'b0}} : zr[31:16]};

endmodule

>>> rtl/complex_lms_two_tap_phase_error.sv
// Two-tap complex LMS combiner. Each transaction on s_axis carries one complex
// sample per antenna; one transaction on m_axis returns the error phase and
// the saturated error d - y. The weight loop (multiply, error, gradient,
// update) handles one item at a time; a two-entry queue then feeds a
// sequential CORDIC, which also takes one item at a time. Writing a
// reference register clears the weights; write configuration only while
// the block is idle.
module complex_lms_two_tap_phase_error import clms_pkg::*; #(
  parameter int unsigned SAMPLE_BITS      = SampleBitsDef,
  parameter int unsigned WEIGHT_BITS      = WeightBitsDef,
  parameter int unsigned PHASE_ITERATIONS = PhaseItersDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxBits-1:0] cfg_idx_i,
  input  logic [((SAMPLE_BITS > MuBits) ? SAMPLE_BITS : MuBits)-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ant0_real, ant0_imag, ant1_real, ant1_imag
  input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // error_phase, error_real, error_imag
  output logic [((2*SAMPLE_BITS+PhaseBits+11)/8)*8-1:0] m_axis_tdata
);

  localparam int unsigned QW = 2*SAMPLE_BITS + 4;
  localparam int unsigned OW = QW + PhaseBits;

  logic [MuBits-1:0] mu_q;
  logic signed [SAMPLE_BITS-1:0] ref_re_q, ref_im_q;
  logic clear;
  logic l_valid, l_ready, c_valid, c_ready;
  logic [QW-1:0] l_data, c_data;
  logic [OW-1:0] p_data;

  assign clear = cfg_we_i && (cfg_idx_i == CfgRefReal || cfg_idx_i == CfgRefImag);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mu_q <= StepSizeRst;
      ref_re_q <= '0;
      ref_im_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgStepSize: mu_q <= cfg_data_i[MuBits-1:0];
        CfgRefReal:  ref_re_q <= cfg_data_i[SAMPLE_BITS-1:0];
        CfgRefImag:  ref_im_q <= cfg_data_i[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  clms_lms #(.SampleBits(SAMPLE_BITS), .WeightBits(WEIGHT_BITS)) u_lms (
    .clk_i, .rst_ni, .clear_i(clear), .mu_i(mu_q),
    .ref_re_i(ref_re_q), .ref_im_i(ref_im_q),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata[4*SAMPLE_BITS-1:0]),
    .out_valid_o(l_valid), .out_ready_i(l_ready), .out_data_o(l_data)
  );

  clms_fifo #(.Width(QW)) u_fifo (
    .clk_i, .rst_ni, .in_valid_i(l_valid), .in_ready_o(l_ready), .in_data_i(l_data),
    .out_valid_o(c_valid), .out_ready_i(c_ready), .out_data_o(c_data)
  );

  clms_phase #(.SampleBits(SAMPLE_BITS), .PhaseIters(PHASE_ITERATIONS)) u_phase (
    .clk_i, .rst_ni, .in_valid_i(c_valid), .in_ready_o(c_ready), .in_data_i(c_data),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready), .out_data_o(p_data)
  );

  assign m_axis_tdata = {{($bits(m_axis_tdata)-OW){1'b0}}, p_data};

`ifndef NO_ASSERTIONS
  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clear |-> !s_axis_tready) else $error("input taken during weight clear");
  a_phase_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[OW-1:PhaseBits] == '0) |->
    m_axis_tdata[PhaseBits-1:0] == '0) else $error("nonzero phase for zero error");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
`endif

endmodule

>>> tb/sv/complex_lms_two_tap_phase_error_tb.sv
`timescale 1ns / 100ps

module complex_lms_two_tap_phase_error_tb;
  import clms_pkg::*;

  localparam int SB = 16;
  localparam int WB = 24;
  localparam int ITERS = 16;
  localparam int WFRAC = WB - 4;
  localparam int SFRAC = SB - 1;
  localparam int EB = SB + 2;
  localparam int UPD = SB - WB + 19;
  localparam int LIMIT = 2000000;
  localparam logic [CfgIdxBits-1:0] CfgUnused = 2'd3;

  typedef struct packed {
    logic signed [17:0] err_im;
    logic signed [17:0] err_re;
    logic signed [15:0] phase;
  } err_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxBits-1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  int cycles = 0;
  bit sink_quiet = 1'b0;

  complex_lms_two_tap_phase_error dut (.*);

  function automatic longint shr_floor(longint x, int n);
    return x >>> n;
  endfunction

  function automatic longint shr_round(longint x, int n);
    return (x + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint x, int bits);
    longint hi, lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic logic [15:0] err_angle(longint re, longint im);
    longint x, y, t;
    logic [31:0] z;
    logic [31:0] zr;
    x = re * 65536;
    y = im * 65536;
    z = '0;
    if (re == 0 && im == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h80000000;
    end
    for (int i = 0; i < ITERS; i++) begin
      if (y > 0) begin
        t = x + shr_floor(y, i);
        y = y - shr_floor(x, i);
        z = z + atan_turn(i[4:0]);
      end else begin
        t = x - shr_floor(y, i);
        y = y + shr_floor(x, i);
        z = z - atan_turn(i[4:0]);
      end
      x = t;
    end
    zr = z + 32'h8000;
    return zr[31:16];
  endfunction

  class lms_scoreboard;
    longint w0r, w0i, w1r, w1i;
    longint mu, dr, di;
    err_out_t pending[$];
    int errors;
    int results;

    function void clear_taps();
      w0r = 0; w0i = 0; w1r = 0; w1i = 0;
    endfunction

    function void init();
      mu = 256; dr = 0; di = 0; errors = 0; results = 0;
      clear_taps();
    endfunction

    function void write_reg(logic [CfgIdxBits-1:0] idx, logic [15:0] v);
      case (idx)
        CfgStepSize: mu = v;
        CfgRefReal: begin
          dr = longint'($signed(v));
          clear_taps();
        end
        CfgRefImag: begin
          di = longint'($signed(v));
          clear_taps();
        end
        default: ;
      endcase
    endfunction

    function longint tap_step(longint w, longint g);
      longint u;
      u = mu * shr_round(g, SFRAC);
      u = UPD > 0 ? shr_round(u, UPD) : (UPD < 0 ? u * (longint'(1) << -UPD) : u);
      return clip(w + u, WB);
    endfunction

    function void note_sample(logic [63:0] d);
      longint ar, ai, br, bi, yr, yi, er, ei;
      err_out_t e;
      ar = longint'($signed(d[15:0]));
      ai = longint'($signed(d[31:16]));
      br = longint'($signed(d[47:32]));
      bi = longint'($signed(d[63:48]));
      yr = w0r * ar - w0i * ai + w1r * br - w1i * bi;
      yi = w0r * ai + w0i * ar + w1r * bi + w1i * br;
      er = clip(shr_round(dr * (longint'(1) << WFRAC) - yr, WFRAC), EB);
      ei = clip(shr_round(di * (longint'(1) << WFRAC) - yi, WFRAC), EB);
      w0r = tap_step(w0r, er * ar + ei * ai);
      w0i = tap_step(w0i, ei * ar - er * ai);
      w1r = tap_step(w1r, er * br + ei * bi);
      w1i = tap_step(w1i, ei * br - er * bi);
      e.phase = err_angle(er, ei);
      e.err_re = er[17:0];
      e.err_im = ei[17:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [55:0] d);
      err_out_t got, exp_r;
      got = d[51:0];
      results++;
      if (pending.size() == 0) begin
        $error("result with nothing pending: %h", d);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.phase !== exp_r.phase) begin
        $error("error_phase exp %0d got %0d", exp_r.phase, got.phase);
        errors++;
      end
      if (got.err_re !== exp_r.err_re) begin
        $error("error_real exp %0d got %0d", exp_r.err_re, got.err_re);
        errors++;
      end
      if (got.err_im !== exp_r.err_im) begin
        $error("error_imag exp %0d got %0d", exp_r.err_im, got.err_im);
        errors++;
      end
    endfunction
  endclass

  lms_scoreboard sb = new();

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout");
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result sink with random stall bursts
  initial begin
    int gap;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (!sink_quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 12);
        m_axis_tready <= 1'b0;
        repeat (gap) begin
          @(posedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
    end
  end

  task automatic send_sample(logic [63:0] d, bit idle_ok);
    int gap;
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_sample(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [15:0] v);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [63:0] rand_pair();
    return {rand_sample(), rand_sample(), rand_sample(), rand_sample()};
  endfunction

  initial begin
    logic [15:0] mus[5];
    logic [15:0] refs[6];
    int sent;
    mus = '{16'd256, 16'd0, 16'hFFFF, 16'd4096, 16'd1};
    refs = '{16'h4000, 16'h8000, 16'h7FFF, 16'h0000, 16'hC000, 16'h1234};
    sb.init();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero error, zero reference and extremes at reset values
    send_sample('0, 1'b0);
    send_sample({4{16'h7FFF}}, 1'b0);
    send_sample({4{16'h8000}}, 1'b0);
    drain();
    write_reg(CfgRefReal, 16'h8000);
    write_reg(CfgRefImag, 16'h0000);
    send_sample({16'h0, 16'h0, 16'h0, 16'h4000}, 1'b0); // phase of pi
    drain();
    write_reg(CfgRefImag, 16'h7FFF);
    write_reg(CfgRefReal, 16'h0000);
    write_reg(CfgStepSize, 16'hFFFF);
    write_reg(CfgUnused, 16'h1111);
    for (int i = 0; i < 12; i++) begin
      send_sample({4{16'h7FFF}} ^ (i[0] ? 64'hFFFF : 64'h0), 1'b0);
    end
    for (int i = 0; i < 6; i++) send_sample(rand_pair(), 1'b0);
    drain();

    sent = 0;
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(CfgStepSize, ph < 5 ? mus[ph] : 16'($urandom()));
      write_reg(CfgRefReal, ph < 6 ? refs[ph] : 16'($urandom()));
      write_reg(CfgRefImag, ph < 6 ? refs[5 - ph] : 16'($urandom()));
      if (ph == 9) sink_quiet = 1'b1;
      for (int i = 0; i < 135; i++) begin
        send_sample(rand_pair(), ph != 9);
        sent++;
        if (i == 60 && ph == 3) drain();
      end
      drain();
    end

    repeat (100) @(posedge clk_i);
    $display("Covered %0d random samples over 10 step-size/reference settings,", sent);
    $display("plus directed extremes; %0d results checked.", sb.results);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> complex_lms_two_tap_phase_error.f
rtl/clms_pkg.sv
rtl/clms_lms.sv
rtl/clms_fifo.sv
rtl/clms_phase.sv
rtl/complex_lms_two_tap_phase_error.sv
tb/sv/complex_lms_two_tap_phase_error_tb.sv
